>>> design/rai_pkg.sv
// Shared types and constants for the ray/annulus intersection pipeline.
// Used by every module of the block; depends on nothing else.
package rai_pkg;

    // Number of radix-2 quotient steps in the divider: one per quotient bit.
    localparam int DIV_STAGES = 63;

    // Largest distance that the result field can show.
    localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_CENTER_X  = 3'd0,
        REG_CENTER_Y  = 3'd1,
        REG_CENTER_Z  = 3'd2,
        REG_NORMAL_X  = 3'd3,
        REG_NORMAL_Y  = 3'd4,
        REG_NORMAL_Z  = 3'd5,
        REG_OUTER_SQ  = 3'd6,
        REG_INNER_SQ  = 3'd7
    } reg_idx_t;

    // Ring description held in configuration.
    typedef struct packed {
        logic [2:0][31:0] center;
        logic [2:0][15:0] normal;
        logic [62:0]      outer_sq;
        logic [62:0]      inner_sq;
    } cfg_t;

    // Side data that travels with each ray through the divider.
    typedef struct packed {
        logic [2:0][32:0] oc;        // origin minus center, signed Q17.16
        logic [2:0][15:0] dir;       // direction, signed Q2.14
        logic             den_zero;  // ray parallel to the plane
        logic             den_neg;   // ray enters from the front side
        logic             sign_diff; // quotient is negative or zero
    } div_tag_t;

    // One result item.
    typedef struct packed {
        logic        entering;
        logic [30:0] distance;
        logic        hit;
    } res_t;

endpackage

>>> design/rai_front.sv
// Front end: dot products of the normal with direction and center offset.
// Three register stages; depends on rai_pkg.
module rai_front
    import rai_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [2:0][31:0] origin,
    input  logic [2:0][15:0] dir,
    input  cfg_t             cfg,
    output logic             out_valid,
    output logic [62:0]      dividend,
    output logic [31:0]      divisor,
    output div_tag_t         tag
);

    logic                    v1_reg, v2_reg, v3_reg;
    logic signed [32:0]      co_reg [3];
    logic signed [32:0]      oc1_reg [3];
    logic signed [31:0]      nd_reg [3];
    logic [2:0][15:0]        dir1_reg, dir2_reg;
    logic signed [48:0]      nc_reg [3];
    logic signed [32:0]      oc2_reg [3];
    logic signed [33:0]      den_reg;
    logic signed [33:0]      den_next;
    logic signed [50:0]      num_next;
    logic [48:0]             num_abs;
    logic [31:0]             den_abs;
    logic [62:0]             dividend_reg;
    logic [31:0]             divisor_reg;
    div_tag_t                tag_reg;

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 1: offsets and the normal-direction products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                co_reg[i]  <= $signed({cfg.center[i][31], cfg.center[i]})
                            - $signed({origin[i][31], origin[i]});
                oc1_reg[i] <= $signed({origin[i][31], origin[i]})
                            - $signed({cfg.center[i][31], cfg.center[i]});
                nd_reg[i]  <= $signed(cfg.normal[i]) * $signed(dir[i]);
            end
            dir1_reg <= dir;
        end
    end

    // Stage 2: normal-offset products and the denominator sum.
    always_comb
    begin
        den_next = 34'(nd_reg[0]) + 34'(nd_reg[1]) + 34'(nd_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nc_reg[i]  <= $signed(cfg.normal[i]) * co_reg[i];
                oc2_reg[i] <= oc1_reg[i];
            end
            den_reg  <= den_next;
            dir2_reg <= dir1_reg;
        end
    end

    // Stage 3: numerator sum, magnitudes and signs for the divider.
    always_comb
    begin
        num_next = 51'(nc_reg[0]) + 51'(nc_reg[1]) + 51'(nc_reg[2]);
        num_abs  = num_next[50] ? 49'(-num_next) : num_next[48:0];
        den_abs  = den_reg[33] ? 32'(-den_reg) : den_reg[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dividend_reg      <= {num_abs, 14'd0};
            divisor_reg       <= den_abs;
            for (int i = 0; i < 3; i++)
            begin
                tag_reg.oc[i] <= oc2_reg[i];
            end
            tag_reg.dir       <= dir2_reg;
            tag_reg.den_zero  <= (den_reg == 34'sd0);
            tag_reg.den_neg   <= den_reg[33];
            tag_reg.sign_diff <= den_reg[33] ^ num_next[50];
        end
    end

    assign out_valid = v3_reg;
    assign dividend  = dividend_reg;
    assign divisor   = divisor_reg;
    assign tag       = tag_reg;

endmodule

>>> design/rai_div.sv
// Pipelined restoring divider: one quotient bit per stage, unsigned magnitudes.
// Carries the ray's side data alongside; depends on rai_pkg.
module rai_div
    import rai_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [62:0] dividend,
    input  logic [31:0] divisor,
    input  div_tag_t    in_tag,
    output logic        out_valid,
    output logic [62:0] quotient,
    output div_tag_t    out_tag
);

    logic        v_reg   [DIV_STAGES];
    logic [31:0] rem_reg [DIV_STAGES];
    logic [62:0] dd_reg  [DIV_STAGES];
    logic [31:0] dv_reg  [DIV_STAGES];
    div_tag_t    tag_reg [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_step
            logic        pv;
            logic [31:0] prem;
            logic [62:0] pdd;
            logic [31:0] pdv;
            div_tag_t    ptag;
            logic [32:0] top;
            logic [32:0] diff;
            logic        qbit;

            if (k == 0)
            begin : g_first
                assign pv   = in_valid;
                assign prem = 32'd0;
                assign pdd  = dividend;
                assign pdv  = divisor;
                assign ptag = in_tag;
            end
            else
            begin : g_rest
                assign pv   = v_reg[k-1];
                assign prem = rem_reg[k-1];
                assign pdd  = dd_reg[k-1];
                assign pdv  = dv_reg[k-1];
                assign ptag = tag_reg[k-1];
            end

            // Trial subtract of the divisor from the shifted remainder.
            always_comb
            begin
                top  = {prem, pdd[62]};
                diff = top - {1'b0, pdv};
                qbit = (top >= {1'b0, pdv});
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= pv;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= qbit ? diff[31:0] : top[31:0];
                    dd_reg[k]  <= {pdd[61:0], qbit};
                    dv_reg[k]  <= pdv;
                    tag_reg[k] <= ptag;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[DIV_STAGES-1];
    assign quotient  = dd_reg[DIV_STAGES-1];
    assign out_tag   = tag_reg[DIV_STAGES-1];

endmodule

>>> design/rai_back.sv
// Back end: hit point, squared radius and band test, six register stages.
// Depends on rai_pkg.
module rai_back
    import rai_pkg::*;
#(
    parameter int MIN_HIT_DISTANCE = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [62:0] quotient,
    input  div_tag_t    tag,
    input  cfg_t        cfg,
    output logic        out_valid,
    output res_t        result
);

    localparam logic [62:0] MinDist = 63'(MIN_HIT_DISTANCE);

    logic               v_reg [6];
    logic               miss1_reg, miss2_reg, miss3_reg, miss4_reg, miss5_reg;
    logic               dneg1_reg [3];
    logic [78:0]        prod_reg  [3];
    logic signed [32:0] oc1_reg   [3];
    logic signed [35:0] h_reg     [3];
    logic [31:0]        ah_reg    [3];
    logic [63:0]        sq_reg    [3];
    logic [63:0]        psq_reg;
    logic [30:0]        dist_reg  [5];
    logic               ent_reg   [5];
    res_t               res_reg;
    logic               far2;
    logic               far3;
    logic [35:0]        habs [3];
    logic [33:0]        mag  [3];
    logic [65:0]        sum_next;
    logic               band_miss;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < 6; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // Stage 1: sign and minimum checks, and the products of t with each |D|.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            miss1_reg <= tag.den_zero
                       || (tag.sign_diff && (quotient != 63'd0))
                       || (quotient < MinDist);
            for (int i = 0; i < 3; i++)
            begin
                dneg1_reg[i] <= tag.dir[i][15];
                prod_reg[i]  <= quotient * (tag.dir[i][15] ? 16'(-tag.dir[i]) : tag.dir[i]);
                oc1_reg[i]   <= $signed(tag.oc[i]);
            end
            dist_reg[0] <= (quotient > 63'(DIST_MAX)) ? DIST_MAX : quotient[30:0];
            ent_reg[0]  <= tag.den_neg;
        end
    end

    // Stage 2: hit point coordinates relative to the center.
    always_comb
    begin
        far2 = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = prod_reg[i][47:14];
            far2   = far2 | (|prod_reg[i][78:48]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                h_reg[i] <= 36'(oc1_reg[i])
                          + (dneg1_reg[i] ? -$signed({2'b00, mag[i]})
                                          :  $signed({2'b00, mag[i]}));
            end
            miss2_reg   <= miss1_reg | far2;
            dist_reg[1] <= dist_reg[0];
            ent_reg[1]  <= ent_reg[0];
        end
    end

    // Stage 3: magnitudes, with a far point taken as a miss.
    always_comb
    begin
        far3 = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            habs[i] = h_reg[i][35] ? 36'(-h_reg[i]) : h_reg[i];
            far3    = far3 | (|habs[i][35:32]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ah_reg[i] <= habs[i][31:0];
            end
            miss3_reg   <= miss2_reg | far3;
            dist_reg[2] <= dist_reg[1];
            ent_reg[2]  <= ent_reg[1];
        end
    end

    // Stage 4: squares.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= ah_reg[i] * ah_reg[i];
            end
            miss4_reg   <= miss3_reg;
            dist_reg[3] <= dist_reg[2];
            ent_reg[3]  <= ent_reg[2];
        end
    end

    // Stage 5: saturating sum of the squares.
    always_comb
    begin
        sum_next = 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            psq_reg     <= (|sum_next[65:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : sum_next[63:0];
            miss5_reg   <= miss4_reg;
            dist_reg[4] <= dist_reg[3];
            ent_reg[4]  <= ent_reg[3];
        end
    end

    // Stage 6: band test and result forming.
    always_comb
    begin
        band_miss = (psq_reg > {1'b0, cfg.outer_sq}) || (psq_reg < {1'b0, cfg.inner_sq});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.hit      <= !(miss5_reg | band_miss);
            res_reg.distance <= (miss5_reg | band_miss) ? 31'd0 : dist_reg[4];
            res_reg.entering <= !(miss5_reg | band_miss) & ent_reg[4];
        end
    end

    assign out_valid = v_reg[5];
    assign result    = res_reg;

endmodule

>>> design/rai_outbuf.sv
// Output register with a skid stage, so the pipeline keeps moving while a
// result waits. Depends on rai_pkg.
module rai_outbuf
    import rai_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  res_t in_data,
    output logic en,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_data
);

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_reg;
    res_t skid_reg;
    logic out_free;

    assign en       = !skid_valid_reg;
    assign out_free = !out_valid_reg || out_ready;

    // Control: the skid fills only when the output holds a waiting result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            if (out_free)
            begin
                out_valid_reg <= in_valid;
            end
            else if (in_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_ready)
        begin
            skid_valid_reg <= 1'b0;
        end
    end

    // Data moves alongside the control above.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (out_free)
            begin
                out_reg <= in_data;
            end
            else
            begin
                skid_reg <= in_data;
            end
        end
        else if (out_ready)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> design/ray_annulus_intersect_core.sv
// Ray/annulus intersection core. Each ray transfer on the input stream gives
// one result transfer, in order. The block is fully pipelined and takes one
// ray per clock unless the input is stalled; a ray passes through three
// dot-product stages, a 63-stage restoring divider (one quotient bit per
// stage, which sets most of the latency) and six hit-point and band-test
// stages, plus the output register. A skid register holds a second result
// while the output waits, so the input stalls only once two results are
// queued at the output. The ring is configured through the APB port; write
// it only while no ray is in flight.
module ray_annulus_intersect_core
    import rai_pkg::*;
#(
    parameter int MIN_HIT_DISTANCE = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    // Ray input. Fields from bit 0: origin_x[31:0], origin_y[31:0],
    // origin_z[31:0], dir_x[15:0], dir_y[15:0], dir_z[15:0].
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,
    // Result output. Fields from bit 0: hit, distance[30:0], entering,
    // then zero fill.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    cfg_t             cfg_reg;
    reg_idx_t         idx;
    logic             en;
    logic [2:0][31:0] origin;
    logic [2:0][15:0] dir;
    logic             f_valid;
    logic [62:0]      f_dividend;
    logic [31:0]      f_divisor;
    div_tag_t         f_tag;
    logic             d_valid;
    logic [62:0]      d_quotient;
    div_tag_t         d_tag;
    logic             b_valid;
    res_t             b_result;
    res_t             out_res;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[5:3]);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center   <= '0;
            cfg_reg.normal   <= {16'd16384, 16'd0, 16'd0};
            cfg_reg.outer_sq <= 63'h1_0000_0000;
            cfg_reg.inner_sq <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_CENTER_X: cfg_reg.center[0] <= pwdata[31:0];
                REG_CENTER_Y: cfg_reg.center[1] <= pwdata[31:0];
                REG_CENTER_Z: cfg_reg.center[2] <= pwdata[31:0];
                REG_NORMAL_X: cfg_reg.normal[0] <= pwdata[15:0];
                REG_NORMAL_Y: cfg_reg.normal[1] <= pwdata[15:0];
                REG_NORMAL_Z: cfg_reg.normal[2] <= pwdata[15:0];
                REG_OUTER_SQ: cfg_reg.outer_sq  <= pwdata[62:0];
                REG_INNER_SQ: cfg_reg.inner_sq  <= pwdata[62:0];
            endcase
        end
    end

    // Configuration reads.
    always_comb
    begin
        unique case (idx)
            REG_CENTER_X: prdata = {32'd0, cfg_reg.center[0]};
            REG_CENTER_Y: prdata = {32'd0, cfg_reg.center[1]};
            REG_CENTER_Z: prdata = {32'd0, cfg_reg.center[2]};
            REG_NORMAL_X: prdata = {48'd0, cfg_reg.normal[0]};
            REG_NORMAL_Y: prdata = {48'd0, cfg_reg.normal[1]};
            REG_NORMAL_Z: prdata = {48'd0, cfg_reg.normal[2]};
            REG_OUTER_SQ: prdata = {1'b0, cfg_reg.outer_sq};
            REG_INNER_SQ: prdata = {1'b0, cfg_reg.inner_sq};
        endcase
    end

    // Unpack the ray fields.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            origin[i] = s_tdata[32*i +: 32];
            dir[i]    = s_tdata[96 + 16*i +: 16];
        end
    end

    assign s_tready = en;

    rai_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .origin    (origin),
        .dir       (dir),
        .cfg       (cfg_reg),
        .out_valid (f_valid),
        .dividend  (f_dividend),
        .divisor   (f_divisor),
        .tag       (f_tag)
    );

    rai_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .dividend  (f_dividend),
        .divisor   (f_divisor),
        .in_tag    (f_tag),
        .out_valid (d_valid),
        .quotient  (d_quotient),
        .out_tag   (d_tag)
    );

    rai_back #(
        .MIN_HIT_DISTANCE (MIN_HIT_DISTANCE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .quotient  (d_quotient),
        .tag       (d_tag),
        .cfg       (cfg_reg),
        .out_valid (b_valid),
        .result    (b_result)
    );

    rai_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid),
        .in_data   (b_result),
        .en        (en),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {7'd0, out_res.entering, out_res.distance, out_res.hit};

endmodule

>>> design/rai_checker.sv
// Port-level checks for the ray/annulus intersection core, and the bind that
// attaches them. Depends on ray_annulus_intersect_core.
module rai_checker
#(
    parameter int MIN_HIT_DISTANCE = 16
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A waiting result stays until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before transfer");

    // A miss carries no distance and no entering flag.
    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[32:1] == 32'd0))
        else $error("miss result with nonzero fields");

    // A hit lies at least the minimum distance away.
    a_hit_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> (m_tdata[31:1] >= 31'(MIN_HIT_DISTANCE)))
        else $error("hit closer than the minimum distance");

    // Input back-pressure only while a result waits at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no waiting result");

    // The output is empty right after reset.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid out of reset");

endmodule

bind ray_annulus_intersect_core rai_checker #(
    .MIN_HIT_DISTANCE (MIN_HIT_DISTANCE)
) u_rai_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
